// ===== rtl/factorization_machine_score_assert.svh =====
// Assertion macros for the factorization machine scorer.
// Included by the top level; needs a clock and an active-low reset name.
`ifndef FACTORIZATION_MACHINE_SCORE_ASSERT_SVH
`define FACTORIZATION_MACHINE_SCORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define FMS_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("factorization_machine_score: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define FMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("factorization_machine_score: next-cycle check failed");

`endif

// ===== rtl/fms_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the factorization machine scorer.
// No dependencies; imported by every module of the block.
package fms_pkg;

  localparam logic signed [63:0] INT64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] INT64_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] INT32_MAX_W = 64'sd2147483647;
  localparam logic signed [63:0] INT32_MIN_W = -64'sd2147483648;

  // Configuration register indexes
  typedef enum logic {
    CFG_ADD_BIAS      = 1'b0,
    CFG_APPLY_SIGMOID = 1'b1
  } cfg_idx_t;

  // One factor accumulator entry: running sum and running sum of squares
  typedef struct packed {
    logic signed [63:0] fs;
    logic signed [63:0] fsq;
  } acc_entry_t;

  // Saturating 64-bit add
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? INT64_MIN : INT64_MAX;
    end
    return s[63:0];
  endfunction

  // Saturate a 64-bit value to the signed 32-bit range
  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > INT32_MAX_W) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < INT32_MIN_W) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Sigmoid of a Q16.16 value with |x| <= 8, result Q16.16.
  // Evaluated on constants only, to build the lookup table.
  function automatic longint sigmoid_q16(input longint x);
    longint a;
    longint t;
    longint t2;
    longint t3;
    longint e;
    longint num;
    longint den;
    longint q;
    longint rem;
    a = (x < 0) ? -x : x;
    t = a << 6;
    t2 = (t * t) >>> 30;
    t3 = (t2 * t) >>> 30;
    e = (longint'(1) << 30) - t + t2 / 2 - t3 / 6;
    for (int i = 0; i < 8; i++) begin
      e = (e * e + (longint'(1) << 29)) >>> 30;
    end
    den = (longint'(1) << 30) + e;
    num = (longint'(1) << 46) + (den >>> 1);
    // restoring long division, quotient bit by bit
    q = 0;
    rem = 0;
    for (int i = 47; i >= 0; i--) begin
      rem = (rem << 1) | ((num >>> i) & longint'(1));
      if (rem >= den) begin
        rem = rem - den;
        q = q | (longint'(1) << i);
      end
    end
    return (x < 0) ? (longint'(65536) - q) : q;
  endfunction

endpackage

// ===== rtl/factorization_machine_score.sv =====
`timescale 1ns / 1ps
// Top level of the factorization machine scorer: handshakes, sequencer and shared adder.
// Depends on fms_pkg, fms_mul, fms_acc_mem, fms_sig_rom and the assertion header.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------------
//   in_     | slave     | in_tvalid/in_tready   | tdata: x, weight, slot; tuser: is_bias; tlast
//   out_    | master    | out_tvalid/out_tready | tdata: score
//   cfg_    | slave     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// A bias, linear or ignored element takes a product and an accumulate step, a factor
// element adds a square and a second accumulate step, all sequenced over one shared
// multiplier and one shared saturating adder. An end-of-row element then walks the
// factor memory (read, square, difference, accumulate per factor), a final sum and, with
// the sigmoid, an index and a table read before the result is loaded into the output register.
// in_tready is high only while the sequencer is idle; a result waiting in the output
// register holds the next end of row at its final step. Reset clears all accumulators.
`include "factorization_machine_score_assert.svh"

module factorization_machine_score
  import fms_pkg::*;
#(
  parameter int FACTORS         = 16,
  parameter int SIGMOID_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // feature_value[31:0], weight_value[63:32], slot[68:64], zero
  input  logic        in_tuser,   // is_bias
  input  logic        in_tlast,   // end_of_row
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // score
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_idx_t    cfg_index,
  input  logic        cfg_data
);

  localparam int AW = (FACTORS > 1) ? $clog2(FACTORS) : 1;
  localparam int IW = $clog2(SIGMOID_ENTRIES);
  localparam logic signed [31:0] SigN = 32'(SIGMOID_ENTRIES);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_PROD = 13'b0000000000010,
    S_ACC1 = 13'b0000000000100,
    S_SQ   = 13'b0000000001000,
    S_ACC2 = 13'b0000000010000,
    W_RD   = 13'b0000000100000,
    W_MUL  = 13'b0000001000000,
    W_DIF  = 13'b0000010000000,
    W_ACC  = 13'b0000100000000,
    S_FIN  = 13'b0001000000000,
    S_SIDX = 13'b0010000000000,
    S_SRD  = 13'b0100000000000,
    S_EMIT = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic add_bias_r;
  logic apply_sig_r;

  // latched element
  logic signed [31:0] x_r;
  logic signed [31:0] w_r;
  logic [AW-1:0]      k_r;
  logic               bias_r;
  logic               slot0_r;
  logic               factor_r;
  logic               eor_r;

  // accumulators and scratch
  logic signed [63:0] linear_r, linear_nxt;
  logic signed [63:0] cross_r, cross_nxt;
  logic signed [63:0] fs_new_r, fs_new_nxt;
  logic signed [63:0] diff_r, diff_nxt;
  logic signed [31:0] p_r, p_nxt;
  logic signed [31:0] tot_r, tot_nxt;
  logic [AW-1:0]      walk_k_r, walk_k_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_data_r, out_data_nxt;

  // shared units
  logic               mul_en;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod_r;
  logic signed [63:0] prod_sh;
  logic signed [63:0] add_a;
  logic signed [63:0] add_b;
  logic signed [63:0] add_sum;

  // memories
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic          mem_wr_en;
  logic          mem_clr;
  acc_entry_t    mem_wr_data;
  acc_entry_t    mem_rd_data;
  logic          rom_rd_en;
  logic [IW-1:0] sig_idx;
  logic [31:0]   rom_data;

  // input decode
  logic          in_fire;
  logic [4:0]    in_slot;
  logic [AW-1:0] in_slot_idx;
  logic          in_factor_ok;
  logic signed [32:0] u33;
  logic          u_neg;
  logic          u_big;
  logic          walk_last;
  logic          out_free;

  assign in_tready    = (state_r == S_IDLE);
  assign in_fire      = in_tvalid && in_tready;
  assign in_slot      = in_tdata[68:64];
  assign in_slot_idx  = AW'(in_slot - 5'd1);
  assign in_factor_ok = (in_slot != 5'd0) && (32'(in_slot) <= FACTORS);
  assign cfg_ready    = 1'b1;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_free     = !out_valid_r || out_tready;

  assign prod_sh   = prod_r >>> 16;
  assign add_sum   = sat_add64(add_a, add_b);
  assign walk_last = (walk_k_r == AW'(FACTORS - 1));

  // sigmoid cell index: offset score by 8.0, scale by table size, clamp at both ends
  assign u33   = 33'(tot_r) + 33'sd524288;
  assign u_neg = u33[32];
  assign u_big = !u_neg && (u33[31:20] != 12'd0);
  always_comb begin
    priority if (u_neg) begin
      sig_idx = '0;
    end else if (u_big) begin
      sig_idx = IW'(SIGMOID_ENTRIES - 1);
    end else begin
      sig_idx = prod_r[20 +: IW];
    end
  end

  assign mem_wr_data.fs  = fs_new_r;
  assign mem_wr_data.fsq = add_sum;

  fms_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  fms_acc_mem #(
    .DEPTH (FACTORS),
    .AW    (AW)
  ) u_acc_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (mem_clr),
    .wr_en   (mem_wr_en),
    .wr_addr (k_r),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  fms_sig_rom #(
    .ENTRIES (SIGMOID_ENTRIES),
    .IW      (IW)
  ) u_sig_rom (
    .clk       (clk),
    .rd_en     (rom_rd_en),
    .rd_addr   (sig_idx),
    .rd_data_r (rom_data)
  );

  // Sequencer: operand selection for the shared units and next-state logic
  always_comb begin
    state_nxt     = state_r;
    linear_nxt    = linear_r;
    cross_nxt     = cross_r;
    fs_new_nxt    = fs_new_r;
    diff_nxt      = diff_r;
    p_nxt         = p_r;
    tot_nxt       = tot_r;
    walk_k_nxt    = walk_k_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    add_a         = '0;
    add_b         = '0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = walk_k_r;
    mem_wr_en     = 1'b0;
    mem_clr       = 1'b0;
    rom_rd_en     = 1'b0;

    // drop the result once the sink takes it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        mem_rd_addr = in_slot_idx;
        if (in_fire) begin
          mem_rd_en = 1'b1;
          state_nxt = S_PROD;
        end
      end
      S_PROD: begin
        mul_en    = 1'b1;
        mul_a     = w_r;
        mul_b     = x_r;
        state_nxt = S_ACC1;
      end
      S_ACC1: begin
        if (bias_r) begin
          add_a      = linear_r;
          add_b      = add_bias_r ? 64'(w_r) : 64'sd0;
          linear_nxt = add_sum;
        end else if (slot0_r) begin
          add_a      = linear_r;
          add_b      = prod_sh;
          linear_nxt = add_sum;
        end else if (factor_r) begin
          add_a      = mem_rd_data.fs;
          add_b      = 64'(clamp32(prod_sh));
          fs_new_nxt = add_sum;
          p_nxt      = clamp32(prod_sh);
        end
        if (factor_r && !bias_r) begin
          state_nxt = S_SQ;
        end else if (eor_r) begin
          cross_nxt  = '0;
          walk_k_nxt = '0;
          state_nxt  = W_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SQ: begin
        mul_en    = 1'b1;
        mul_a     = p_r;
        mul_b     = p_r;
        state_nxt = S_ACC2;
      end
      S_ACC2: begin
        add_a     = mem_rd_data.fsq;
        add_b     = prod_sh;
        mem_wr_en = 1'b1;
        if (eor_r) begin
          cross_nxt  = '0;
          walk_k_nxt = '0;
          state_nxt  = W_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      W_RD: begin
        mem_rd_en = 1'b1;
        state_nxt = W_MUL;
      end
      W_MUL: begin
        mul_en    = 1'b1;
        mul_a     = clamp32(mem_rd_data.fs);
        mul_b     = clamp32(mem_rd_data.fs);
        state_nxt = W_DIF;
      end
      W_DIF: begin
        add_a     = prod_sh;
        add_b     = -mem_rd_data.fsq;
        diff_nxt  = add_sum;
        state_nxt = W_ACC;
      end
      W_ACC: begin
        add_a     = cross_r;
        add_b     = diff_r;
        cross_nxt = add_sum;
        if (walk_last) begin
          state_nxt = S_FIN;
        end else begin
          walk_k_nxt = walk_k_r + AW'(1);
          state_nxt  = W_RD;
        end
      end
      S_FIN: begin
        add_a     = linear_r;
        add_b     = cross_r >>> 1;
        tot_nxt   = clamp32(add_sum);
        state_nxt = apply_sig_r ? S_SIDX : S_EMIT;
      end
      S_SIDX: begin
        mul_en    = 1'b1;
        mul_a     = $signed({11'b0, u33[20:0]});
        mul_b     = SigN;
        state_nxt = S_SRD;
      end
      S_SRD: begin
        rom_rd_en = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // load the result and clear the row once the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = apply_sig_r ? rom_data : tot_r;
          linear_nxt    = '0;
          mem_clr       = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      linear_r    <= '0;
      add_bias_r  <= 1'b1;
      apply_sig_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      linear_r    <= linear_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ADD_BIAS:      add_bias_r  <= cfg_data;
          CFG_APPLY_SIGMOID: apply_sig_r <= cfg_data;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cross_r    <= cross_nxt;
    fs_new_r   <= fs_new_nxt;
    diff_r     <= diff_nxt;
    p_r        <= p_nxt;
    tot_r      <= tot_nxt;
    walk_k_r   <= walk_k_nxt;
    out_data_r <= out_data_nxt;
  end

  // Hold the accepted element for the duration of its sequence
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r      <= in_tdata[31:0];
      w_r      <= in_tdata[63:32];
      k_r      <= in_slot_idx;
      bias_r   <= in_tuser;
      slot0_r  <= (in_slot == 5'd0);
      factor_r <= in_factor_ok;
      eor_r    <= in_tlast;
    end
  end

  // Assertions
  `FMS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_tready)
  `FMS_ASSERT_HOLDS(a_walk_in_range, clk, rst_n, (state_r == W_RD) || (state_r == W_ACC), 32'(walk_k_r) < FACTORS)
  `FMS_ASSERT_NEXT(a_emit_waits, clk, rst_n, (state_r == S_EMIT) && !out_free, (state_r == S_EMIT) && out_valid_r)
  `FMS_ASSERT_HOLDS(a_sig_idx_range, clk, rst_n, state_r == S_SRD, 32'(sig_idx) < SIGMOID_ENTRIES)

endmodule

// ===== rtl/fms_mul.sv =====
`timescale 1ns / 1ps
// Shared 32x32 signed multiplier with a registered 64-bit product.
// Depends on fms_pkg.
module fms_mul
  import fms_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod_r
);

  logic signed [63:0] full;

  assign full = a * b;

  // Capture the exact product when the sequencer asks for it
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= full;
    end
  end

endmodule

// ===== rtl/fms_acc_mem.sv =====
`timescale 1ns / 1ps
// Per-factor accumulator memory: one write port, one registered read port,
// a valid bit per entry so that unwritten or cleared entries read as zero. Depends on fms_pkg.
module fms_acc_mem
  import fms_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  acc_entry_t    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output acc_entry_t    rd_data
);

  acc_entry_t       mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  acc_entry_t       mem_q_r;
  logic             vld_q_r;

  // Store entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Track written entries; clear all at once at end of row
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
      vld_q_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = vld_q_r ? mem_q_r : '0;

endmodule

// ===== rtl/fms_sig_rom.sv =====
`timescale 1ns / 1ps
// Sigmoid lookup table: equal cells over [-8, 8), each holding the sigmoid of its center.
// Contents are built at elaboration from fms_pkg::sigmoid_q16; read data is registered.
module fms_sig_rom
  import fms_pkg::*;
#(
  parameter int ENTRIES = 256,
  parameter int IW      = 8
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic [31:0]   rd_data_r
);

  logic [31:0] rom [ENTRIES];

  // Fill each cell with the sigmoid of the cell center
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    localparam longint Center =
      ((longint'(2 * g + 1) << 19) / ENTRIES) - (longint'(1) << 19);
    assign rom[g] = 32'(sigmoid_q16(Center));
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= rom[rd_addr];
    end
  end

endmodule

// ===== test/factorization_machine_score_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the factorization machine scorer: directed table, then random rows.
// Depends on fms_pkg (configuration register indexes) and the factorization_machine_score RTL.
module factorization_machine_score_test;
  import fms_pkg::*;

  localparam int     FACTORS      = 16;
  localparam int     TABLE_CELLS  = 256;
  localparam int     RANDOM_ITEMS = 1500;
  localparam int     PHASES       = 8;
  localparam int     SETTLE       = 4 * FACTORS + 60;
  localparam int     IDLE_LIMIT   = 3000;
  localparam longint LONG_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint LONG_MIN     = -LONG_MAX - 1;
  localparam longint WORD_MAX     = 64'sd2147483647;
  localparam longint WORD_MIN     = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] w;
    logic [4:0]         slot;
    bit                 bias;
    bit                 last;
    bit                 pinned;        // score typed into the table
    logic [31:0]        pinned_score;
  } elem_row_t;

  typedef struct {
    logic [31:0] score;
    int          row;
  } score_exp_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // feature_value[31:0], weight_value[63:32], slot[68:64], zero
  logic        in_tuser;   // is_bias
  logic        in_tlast;   // end_of_row
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // score
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_idx_t    cfg_index;
  logic        cfg_data;

  // Predictor state: configuration and row accumulators
  bit          add_bias_r = 1'b1;
  bit          sigmoid_r  = 1'b0;
  longint      lin_acc;
  longint      fac_sum [FACTORS];
  longint      fac_sq  [FACTORS];

  elem_row_t   stim_rows [$];
  score_exp_t  score_q [$];
  int          rows_sent;
  int          mismatches;
  int          idle_cycles;
  bit          calm;

  factorization_machine_score #(
    .FACTORS        (FACTORS),
    .SIGMOID_ENTRIES(TABLE_CELLS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- arithmetic
  function automatic longint sat_sum64(input longint a, input longint b);
    if (b > 0 && a > LONG_MAX - b) begin
      return LONG_MAX;
    end
    if (b < 0 && a < LONG_MIN - b) begin
      return LONG_MIN;
    end
    return a + b;
  endfunction

  function automatic longint clip32(input longint v);
    if (v > WORD_MAX) begin
      return WORD_MAX;
    end
    if (v < WORD_MIN) begin
      return WORD_MIN;
    end
    return v;
  endfunction

  // Logistic of a Q16.16 value, |z| <= 8: Q30 exponential by series then squarings
  function automatic longint logistic_q16(input longint z);
    longint a;
    longint t;
    longint t2;
    longint t3;
    longint e;
    longint den;
    longint pos;
    int     i;
    a = (z < 0) ? -z : z;
    t = a <<< 6;
    t2 = (t * t) >>> 30;
    t3 = (t2 * t) >>> 30;
    e = (64'sd1 <<< 30) - t + t2 / 2 - t3 / 6;
    for (i = 0; i < 8; i++) begin
      e = (e * e + (64'sd1 <<< 29)) >>> 30;
    end
    den = (64'sd1 <<< 30) + e;
    pos = ((64'sd1 <<< 46) + den / 2) / den;
    return (z < 0) ? 64'sd65536 - pos : pos;
  endfunction

  // Map a score to its table cell over [-8, 8) and return the cell center's logistic
  function automatic longint logistic_cell(input longint score);
    longint u;
    longint idx;
    longint center;
    u = score + 64'sd524288;
    idx = (u < 0) ? 64'sd0 : (u * TABLE_CELLS) >>> 20;
    if (idx > TABLE_CELLS - 1) begin
      idx = TABLE_CELLS - 1;
    end
    center = ((2 * idx + 1) <<< 19) / TABLE_CELLS - 64'sd524288;
    return logistic_q16(center);
  endfunction

  // Fold one element into the row; on end of row produce the score and clear
  function automatic bit score_element(input elem_row_t r, output logic [31:0] score);
    longint prod;
    longint p;
    longint s;
    longint cross_acc;
    longint total;
    int     k;
    score = '0;
    prod = longint'(r.w) * longint'(r.x);
    if (r.bias) begin
      if (add_bias_r) begin
        lin_acc = sat_sum64(lin_acc, longint'(r.w));
      end
    end else if (r.slot == 0) begin
      lin_acc = sat_sum64(lin_acc, prod >>> 16);
    end else if (r.slot <= FACTORS) begin
      k = r.slot - 1;
      p = clip32(prod >>> 16);
      fac_sum[k] = sat_sum64(fac_sum[k], p);
      fac_sq[k] = sat_sum64(fac_sq[k], (p * p) >>> 16);
    end
    if (!r.last) begin
      return 1'b0;
    end
    cross_acc = 0;
    for (k = 0; k < FACTORS; k++) begin
      s = clip32(fac_sum[k]);
      cross_acc = sat_sum64(cross_acc, ((s * s) >>> 16) - fac_sq[k]);
    end
    total = clip32(sat_sum64(lin_acc, cross_acc >>> 1));
    if (sigmoid_r) begin
      total = logistic_cell(total);
    end
    score = total[31:0];
    lin_acc = 0;
    for (k = 0; k < FACTORS; k++) begin
      fac_sum[k] = 0;
      fac_sq[k] = 0;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic void add_row(input logic signed [31:0] x, input logic signed [31:0] w,
                                  input logic [4:0] slot, input bit bias, input bit last,
                                  input bit pinned, input logic [31:0] pinned_score);
    elem_row_t r;
    r = '{x, w, slot, bias, last, pinned, pinned_score};
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  // Mostly small values near the sigmoid window, some raw bits and extremes
  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      default: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
    endcase
  endfunction

  function automatic elem_row_t make_elem(input bit last);
    elem_row_t r;
    int        pick;
    pick = $urandom_range(0, 99);
    r.x = rand_q16();
    r.w = rand_q16();
    r.bias = (pick < 8);
    if (pick < 8) begin
      r.slot = 5'($urandom_range(0, 31));
    end else if (pick < 14) begin
      r.slot = 5'($urandom_range(FACTORS + 1, 31));
    end else if (pick < 40) begin
      r.slot = 5'd0;
    end else begin
      // favor a few factors so squares of sums differ from sums of squares
      r.slot = $urandom_range(0, 1) ? 5'($urandom_range(1, 3))
                                    : 5'($urandom_range(1, FACTORS));
    end
    r.last = last;
    r.pinned = 1'b0;
    r.pinned_score = '0;
    return r;
  endfunction

  // Present one element, hold until the transfer, then predict
  task automatic send_elem(input elem_row_t r);
    logic [31:0] predicted;
    score_exp_t  pending;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 13) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, r.slot, r.w, r.x};
    in_tuser <= r.bias;
    in_tlast <= r.last;
    do @(posedge clk); while (!in_tready);
    if (score_element(r, predicted)) begin
      if (r.pinned) begin
        predicted = r.pinned_score;
      end
      pending = '{predicted, rows_sent};
      score_q.insert(score_q.size(), pending);
      rows_sent++;
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input bit value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ADD_BIAS:      add_bias_r = value;
      CFG_APPLY_SIGMOID: sigmoid_r = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every pending score, then let the pipeline go quiet
  task automatic drain_and_settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (score_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input int row, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("MISMATCH %s (row %0d): expected %h, got %h", what, row, want, got);
    mismatches++;
  endtask

  // ---------------------------------------------------------------- main sequence
  initial begin : run
    int phase;
    int len;
    int j;
    int random_sent;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ADD_BIAS;
    cfg_data = 1'b0;
    calm = 1'b0;
    random_sent = 0;

    // x, w, slot, bias, last, pinned, score
    add_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5'd31, 0, 1, 1, 32'h0000_0000); // ignored only
    add_row(32'sh8000_0000, 32'sh0005_0000, 5'd31, 1, 1, 1, 32'h0005_0000); // bias only
    add_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5'd0,  0, 1, 1, 32'h7FFF_FFFF);
    add_row(32'sh8000_0000, 32'sh7FFF_FFFF, 5'd0,  0, 1, 1, 32'h8000_0000);
    add_row(32'sh8000_0000, 32'sh8000_0000, 5'd0,  0, 1, 1, 32'h7FFF_FFFF);
    add_row(32'sh0002_0000, 32'sh0003_0000, 5'd1,  0, 1, 1, 32'h0000_0000); // lone factor
    add_row(32'sh8000_0000, 32'sh8000_0000, 5'd16, 0, 1, 1, 32'h0000_0000);
    add_row(32'sh0001_0000, 32'sh0002_0000, 5'd3,  0, 0, 0, 32'h0);
    add_row(32'sh0001_0000, 32'sh0003_0000, 5'd3,  0, 1, 1, 32'h0006_0000); // (25-13)/2
    add_row(32'sh0000_0000, 32'sh0000_0000, 5'd0,  0, 1, 1, 32'h0000_0000);
    add_row(32'sh1234_5678, -32'sh0001_0000, 5'd0, 1, 0, 0, 32'h0);
    add_row(32'sh0001_8000, -32'sh0002_0000, 5'd0, 0, 0, 0, 32'h0);
    add_row(-32'sh0000_C000, 32'sh0000_8000, 5'd2, 0, 0, 0, 32'h0);
    add_row(32'sh0002_4000, -32'sh0001_4000, 5'd2, 0, 0, 0, 32'h0);
    add_row(32'sh0000_8000, -32'sd1,         5'd5, 0, 0, 0, 32'h0);
    add_row(32'sh5A5A_5A5A, 32'sh0F0F_0F0F,  5'd17, 0, 0, 0, 32'h0);
    add_row(32'sh0001_0000, 32'sh0001_0000,  5'd2, 0, 1, 0, 32'h0);
    add_row(-32'sd1, -32'sd1,                5'd0, 0, 1, 0, 32'h0);
    add_row(-32'sd1, 32'sh0001_0000,         5'd0, 0, 1, 0, 32'h0);
    add_row(32'shAAAA_AAAA, 32'sh5555_5555,  5'd10, 0, 0, 0, 32'h0);
    add_row(32'sh5555_5555, 32'shAAAA_AAAA,  5'd10, 0, 1, 0, 32'h0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table at reset configuration
    foreach (stim_rows[i]) begin
      send_elem(stim_rows[i]);
    end

    // Random rows, one configuration per phase; the first four cover all combinations
    for (phase = 0; phase < PHASES; phase++) begin
      drain_and_settle();
      write_reg(CFG_ADD_BIAS, (phase < 4) ? phase[0] : 1'($urandom_range(0, 1)));
      write_reg(CFG_APPLY_SIGMOID, (phase < 4) ? phase[1] : 1'($urandom_range(0, 1)));
      calm = (phase == 5);
      while (random_sent < (phase + 1) * RANDOM_ITEMS / PHASES) begin
        len = $urandom_range(1, 12);
        for (j = 0; j < len; j++) begin
          send_elem(make_elem(j == len - 1));
          random_sent++;
        end
      end
    end
    calm = 1'b0;

    drain_and_settle();
    while (score_q.size() != 0) begin
      report_mismatch("score never produced", score_q[0].row, score_q[0].score, 'x);
      void'(score_q.pop_front());
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: stall at random except during the calm stretch
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= calm || ($urandom_range(0, 99) >= 13);
    end
  end

  // Compare each score transfer against the oldest prediction
  always @(posedge clk) begin : check_scores
    score_exp_t head;
    if (rst_n && out_tvalid && out_tready) begin
      if (score_q.size() == 0) begin
        report_mismatch("score with none pending", -1, 'x, out_tdata);
      end else begin
        head = score_q.pop_front();
        if (out_tdata !== head.score) begin
          report_mismatch("score", head.row, head.score, out_tdata);
        end
      end
    end
  end

  // End the run if no transfer happens on any channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TIMEOUT: no transfer for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule
